// File: rtl/bffa_pkg.sv
`timescale 1ns / 1ps

package bffa_pkg;

  // map geometry
  localparam int MAP_BYTES     = 16;
  localparam int BITS_PER_BYTE = 8;
  localparam int CAPACITY      = MAP_BYTES * BITS_PER_BYTE;

  // the map is held as words of up to four bytes, scanned one word per read
  localparam int WORD_BYTES = (MAP_BYTES % 4 == 0) ? 4 : ((MAP_BYTES % 2 == 0) ? 2 : 1);
  localparam int WORD_BITS  = WORD_BYTES * BITS_PER_BYTE;
  localparam int NUM_WORDS  = MAP_BYTES / WORD_BYTES;
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // field widths
  localparam int FUNC_W   = 2;
  localparam int UNIT_W   = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 2'd0,
    FN_MARK    = 2'd1,
    FN_RELEASE = 2'd2,
    FN_TEST    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic latch_req;
    logic rd_en;
    logic next_word;
    logic commit;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic full;
    logic found;
    logic last_word;
    logic out_busy;
  } sts_t;

endpackage

// File: rtl/bitmap_first_free_allocator_top.sv
`timescale 1ns / 1ps

// bitmap first-fit unit allocator
//
// input channel: in_valid_i / in_stall_o carry one request item, func_i
// (allocate, mark, release, test) and unit_number_i (1-based, ignored for
// allocate). an item is taken when in_valid_i is high and in_stall_o low.
// output channel: out_valid_o / out_stall_i carry one result item per
// request: allocated_number_o, bit_value_o, status_o and free_units_o.
//
// timing: after accept the sequencer steps through read, evaluate and done;
// the result moves from done into the output register. allocate reads one
// 32-bit map word per read / evaluate pass and stops at the first word with
// a clear bit, at the last word, or at once when the counter is zero. one
// item is in flight at a time; in_stall_o is high from accept until the
// result moves into the output register.
//
// reset: the map clears to all free and the counter loads the capacity
// in the same cycle, no clearing pass. while the receiver stalls, the
// result holds in the output register; a finished next item waits
// internally until that register is taken.

module bitmap_first_free_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bffa_pkg::FUNC_W-1:0]   func_i,
  input  logic [bffa_pkg::UNIT_W-1:0]   unit_number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bffa_pkg::UNIT_W-1:0]   allocated_number_o,
  output logic                          bit_value_o,
  output logic [bffa_pkg::STATUS_W-1:0] status_o,
  output logic [bffa_pkg::UNIT_W-1:0]   free_units_o
);

  bffa_pkg::cmd_t cmd;
  bffa_pkg::sts_t sts;

  // sequencer: accept, read word, evaluate, hand off result
  bffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // map words, free counter, scan and output register
  bffa_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .func_i             (func_i),
    .unit_number_i      (unit_number_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .allocated_number_o (allocated_number_o),
    .bit_value_o        (bit_value_o),
    .status_o           (status_o),
    .free_units_o       (free_units_o)
  );

  // one item at a time: no second accept right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // a result never overwrites one that the receiver is still holding off
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("pending result overwritten");

  // a full report gives no unit and a zero counter
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bffa_pkg::ST_FULL) |->
      (allocated_number_o == '0 && free_units_o == '0 && !bit_value_o))
    else $error("full result inconsistent");

  // the counter never passes the capacity
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(free_units_o) <= bffa_pkg::CAPACITY))
    else $error("free count above capacity");

endmodule

// File: rtl/bffa_ctrl.sv
`timescale 1ns / 1ps

module bffa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bffa_pkg::sts_t  sts_i,
  output bffa_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        // keep scanning while an allocate with a nonzero counter has not found a clear bit and words remain
        if (sts_i.is_alloc && !sts_i.full && !sts_i.found && !sts_i.last_word) begin
          cmd_o.next_word = 1'b1;
          state_d         = S_READ;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/bffa_datapath.sv
`timescale 1ns / 1ps

module bffa_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bffa_pkg::cmd_t                cmd_i,
  output bffa_pkg::sts_t                sts_o,
  input  logic [bffa_pkg::FUNC_W-1:0]   func_i,
  input  logic [bffa_pkg::UNIT_W-1:0]   unit_number_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [bffa_pkg::UNIT_W-1:0]   allocated_number_o,
  output logic                          bit_value_o,
  output logic [bffa_pkg::STATUS_W-1:0] status_o,
  output logic [bffa_pkg::UNIT_W-1:0]   free_units_o
);

  localparam int IDX_W  = bffa_pkg::IDX_W;
  localparam int OFF_W  = bffa_pkg::OFF_W;
  localparam int WIDX_W = bffa_pkg::WIDX_W;
  localparam int CNT_W  = bffa_pkg::CNT_W;
  localparam int UNIT_W = bffa_pkg::UNIT_W;
  localparam int WBITS  = bffa_pkg::WORD_BITS;

  // allocation map and free counter
  logic [WBITS-1:0] map_q [bffa_pkg::NUM_WORDS];
  logic [CNT_W-1:0] free_q;

  // request and scan registers
  logic [bffa_pkg::FUNC_W-1:0] func_q;
  logic [UNIT_W-1:0]           unit_q;
  logic [WIDX_W-1:0]           widx_q;
  logic [WBITS-1:0]            rd_q;

  // pending result
  logic [UNIT_W-1:0]             res_num_q;
  logic                          res_bit_q;
  logic [bffa_pkg::STATUS_W-1:0] res_status_q;

  logic                          out_valid_q;
  logic [UNIT_W-1:0]             out_num_q;
  logic                          out_bit_q;
  logic [bffa_pkg::STATUS_W-1:0] out_status_q;
  logic [UNIT_W-1:0]             out_free_q;

  // word index of an incoming unit number
  logic              in_range_new;
  logic [IDX_W-1:0]  bidx_new;
  logic [WIDX_W-1:0] widx_new;

  assign in_range_new = (unit_number_i != '0) && (int'(unit_number_i) <= bffa_pkg::CAPACITY);
  assign bidx_new     = IDX_W'(unit_number_i - UNIT_W'(1));
  assign widx_new     = in_range_new ? WIDX_W'(bidx_new >> OFF_W) : '0;

  // latched request decode
  logic             in_range;
  logic [IDX_W-1:0] bidx;
  logic [OFF_W-1:0] boff;
  logic [WBITS-1:0] bmask;

  assign in_range = (unit_q != '0) && (int'(unit_q) <= bffa_pkg::CAPACITY);
  assign bidx     = IDX_W'(unit_q - UNIT_W'(1));
  assign boff     = bidx[OFF_W-1:0];
  assign bmask    = WBITS'(1) << boff;

  // lowest clear bit of the word just read
  logic             found;
  logic [OFF_W-1:0] pos;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = WBITS - 1; i >= 0; i--) begin
      if (!rd_q[i]) begin
        found = 1'b1;
        pos   = OFF_W'(i);
      end
    end
  end

  logic             full;
  logic [IDX_W:0]   alloc_idx;
  logic [CNT_W-1:0] free_dec;
  logic [CNT_W-1:0] free_inc;

  assign full      = (free_q == '0);
  assign alloc_idx = ((IDX_W + 1)'(widx_q) << OFF_W) + (IDX_W + 1)'(pos) + (IDX_W + 1)'(1);
  assign free_dec  = full ? free_q : free_q - CNT_W'(1);
  assign free_inc  = (free_q == CNT_W'(bffa_pkg::CAPACITY)) ? free_q : free_q + CNT_W'(1);

  assign sts_o.is_alloc  = (func_q == bffa_pkg::FN_ALLOC);
  assign sts_o.full      = full;
  assign sts_o.found     = found;
  assign sts_o.last_word = (widx_q == WIDX_W'(bffa_pkg::NUM_WORDS - 1));
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  // map and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < bffa_pkg::NUM_WORDS; w++) begin
        map_q[w] <= '0;
      end
      free_q <= CNT_W'(bffa_pkg::CAPACITY);
    end else if (cmd_i.commit) begin
      case (func_q)
        bffa_pkg::FN_ALLOC: begin
          if (!full && found) begin
            map_q[widx_q] <= rd_q | (WBITS'(1) << pos);
            free_q        <= free_dec;
          end
        end
        bffa_pkg::FN_MARK: begin
          if (in_range) begin
            map_q[widx_q] <= rd_q | bmask;
            free_q        <= free_dec;
          end
        end
        bffa_pkg::FN_RELEASE: begin
          if (in_range) begin
            map_q[widx_q] <= rd_q & ~bmask;
            free_q        <= free_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request, read word and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      func_q <= func_i;
      unit_q <= unit_number_i;
      widx_q <= (func_i == bffa_pkg::FN_ALLOC) ? '0 : widx_new;
    end else if (cmd_i.next_word) begin
      widx_q <= widx_q + WIDX_W'(1);
    end
    if (cmd_i.rd_en) begin
      rd_q <= map_q[widx_q];
    end
    if (cmd_i.commit) begin
      res_num_q    <= '0;
      res_bit_q    <= 1'b0;
      res_status_q <= bffa_pkg::ST_OK;
      case (func_q)
        bffa_pkg::FN_ALLOC: begin
          if (full) begin
            res_status_q <= bffa_pkg::ST_FULL;
          end else if (found) begin
            res_num_q <= UNIT_W'(alloc_idx);
            res_bit_q <= 1'b1;
          end else begin
            res_status_q <= bffa_pkg::ST_NOT_FOUND;
          end
        end
        bffa_pkg::FN_MARK: begin
          res_bit_q <= in_range;
        end
        bffa_pkg::FN_RELEASE: begin
          res_bit_q <= 1'b0;
        end
        default: begin
          res_bit_q <= in_range && rd_q[boff];
        end
      endcase
    end
    if (cmd_i.load_out) begin
      out_num_q    <= res_num_q;
      out_bit_q    <= res_bit_q;
      out_status_q <= res_status_q;
      out_free_q   <= UNIT_W'(free_q);
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign allocated_number_o = out_num_q;
  assign bit_value_o        = out_bit_q;
  assign status_o           = out_status_q;
  assign free_units_o       = out_free_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // generous ceiling on run length, far above the slowest correct run
  localparam int CYCLE_LIMIT  = 400000;
  // approximate number of random request items
  localparam int RANDOM_ITEMS = 1400;
  // long receiver hold-off, enough to fill the block and back up its input
  localparam int HOLD_CYCLES  = 300;
  // quiet cycles after the last result, covers the longest allocate scan
  localparam int TAIL_CYCLES  = 24;

  // one result item of the allocator
  typedef struct {
    logic [bffa_pkg::UNIT_W-1:0] alloc_num;
    logic                        bit_val;
    bffa_pkg::status_e           status;
    logic [bffa_pkg::UNIT_W-1:0] free_cnt;
  } alloc_result_t;

  // one row of the directed table
  typedef struct {
    bffa_pkg::func_e func;
    logic [7:0]      unit;
    bit              typed;
    alloc_result_t   res;
  } request_row_t;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic [bffa_pkg::FUNC_W-1:0]   func          = bffa_pkg::FN_ALLOC;
  logic [bffa_pkg::UNIT_W-1:0]   unit_number   = '0;
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic [bffa_pkg::UNIT_W-1:0]   allocated_number;
  logic                          bit_value;
  logic [bffa_pkg::STATUS_W-1:0] status;
  logic [bffa_pkg::UNIT_W-1:0]   free_units;

  bitmap_first_free_allocator_top i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .func_i             (func),
    .unit_number_i      (unit_number),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .allocated_number_o (allocated_number),
    .bit_value_o        (bit_value),
    .status_o           (status),
    .free_units_o       (free_units)
  );

  // shadow copy of the allocator state
  bit [bffa_pkg::CAPACITY-1:0] unit_used;
  int                          free_count;

  // results still owed by the block, oldest first
  alloc_result_t pending_results[$];
  request_row_t  directed_rows[$];

  int error_count   = 0;
  int cycle_count   = 0;
  int items_sent    = 0;
  int burst_left    = 0;
  // bumped by the stimulus each time it wants a long receiver hold-off
  int hold_requests = 0;

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run ceiling
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // expected result of one request; updates the shadow state as the block would
  function automatic alloc_result_t predict_request(input bffa_pkg::func_e f,
                                                    input logic [7:0] u);
    alloc_result_t r;
    bit            hit;
    int            k;
    r.alloc_num = '0;
    r.bit_val   = 1'b0;
    r.status    = bffa_pkg::ST_OK;
    hit         = 1'b0;
    if (f == bffa_pkg::FN_ALLOC) begin
      // full: counter is zero, the map is not even looked at
      if (free_count == 0) begin
        r.status = bffa_pkg::ST_FULL;
      end else begin
        // nonzero counter but possibly no clear bit left
        r.status = bffa_pkg::ST_NOT_FOUND;
        for (k = 0; k < bffa_pkg::CAPACITY; k++) begin
          if (!hit && !unit_used[k]) begin
            unit_used[k] = 1'b1;
            free_count--;
            r.alloc_num  = 8'(k + 1);
            r.bit_val    = 1'b1;
            r.status     = bffa_pkg::ST_OK;
            hit          = 1'b1;
          end
        end
      end
    end else if (u >= 1 && u <= bffa_pkg::CAPACITY) begin
      // mark and release move the counter whether the bit changes or not
      case (f)
        bffa_pkg::FN_MARK: begin
          unit_used[u-1] = 1'b1;
          if (free_count > 0) free_count--;
          r.bit_val = 1'b1;
        end
        bffa_pkg::FN_RELEASE: begin
          unit_used[u-1] = 1'b0;
          if (free_count < bffa_pkg::CAPACITY) free_count++;
        end
        default: begin
          r.bit_val = unit_used[u-1];
        end
      endcase
    end
    // out of range unit numbers fall through with the state untouched
    r.free_cnt = 8'(free_count);
    return r;
  endfunction

  // mostly valid unit numbers, some zero or above capacity
  function automatic logic [7:0] pick_unit();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(1, bffa_pkg::CAPACITY));
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one request item in bursts with random gaps; returns at the accepting edge
  task automatic send_request(input bffa_pkg::func_e f, input logic [7:0] u, input bit typed,
                              input alloc_result_t typed_res);
    alloc_result_t pred;
    int            gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
    end
    in_valid    <= 1'b1;
    func        <= f;
    unit_number <= u;
    // accepted at the first edge where the block does not stall
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
    pred = predict_request(f, u);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic send_plain(input bffa_pkg::func_e f, input logic [7:0] u);
    alloc_result_t none;
    none.alloc_num = '0;
    none.bit_val   = 1'b0;
    none.status    = bffa_pkg::ST_OK;
    none.free_cnt  = '0;
    send_request(f, u, 1'b0, none);
  endtask

  // sender stops offering until every owed result has come back
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input bffa_pkg::func_e f, input logic [7:0] u, input bit typed,
                         input logic [7:0] a, input logic b, input bffa_pkg::status_e s,
                         input logic [7:0] n);
    request_row_t row;
    row.func          = f;
    row.unit          = u;
    row.typed         = typed;
    row.res.alloc_num = a;
    row.res.bit_val   = b;
    row.res.status    = s;
    row.res.free_cnt  = n;
    directed_rows.push_back(row);
  endtask

  // receiver: stall density changes by segment, long hold-off on request
  initial begin : receiver
    int stall_pct;
    int seg_left;
    int hold_left;
    int holds_seen;
    stall_pct  = 0;
    seg_left   = 0;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        hold_left  = HOLD_CYCLES;
        holds_seen = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 80;
          endcase
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // result checker: every taken result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        alloc_result_t want;
        want = pending_results.pop_front();
        check_field("allocated_number", allocated_number, want.alloc_num);
        check_field("bit_value", {7'd0, bit_value}, {7'd0, want.bit_val});
        check_field("status", {6'd0, status}, {6'd0, want.status});
        check_field("free_units", free_units, want.free_cnt);
      end
    end
  end

  initial begin : stimulus
    int  phase;
    int  n;
    int  i;
    int  kind;
    bit  mid_hold_done;
    logic [7:0] u;
    unit_used     = '0;
    free_count    = bffa_pkg::CAPACITY;
    mid_hold_done = 1'b0;

    // directed table; typed expectations only where the value is obvious
    add_row(bffa_pkg::FN_TEST,    8'd1,   1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd128);  // clean map
    add_row(bffa_pkg::FN_TEST,    8'd0,   1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd128);  // unit zero
    add_row(bffa_pkg::FN_MARK,    8'd0,   1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd128);
    add_row(bffa_pkg::FN_RELEASE, 8'd129, 1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd128);  // too high
    add_row(bffa_pkg::FN_TEST,    8'd255, 1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd128);
    add_row(bffa_pkg::FN_MARK,    8'd200, 1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd128);
    add_row(bffa_pkg::FN_RELEASE, 8'd1,   1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd128);  // held
    add_row(bffa_pkg::FN_ALLOC,   8'd255, 1, 8'd1, 1'b1, bffa_pkg::ST_OK, 8'd127);  // unit ignored
    add_row(bffa_pkg::FN_ALLOC,   8'd0,   1, 8'd2, 1'b1, bffa_pkg::ST_OK, 8'd126);
    add_row(bffa_pkg::FN_MARK,    8'd128, 1, 8'd0, 1'b1, bffa_pkg::ST_OK, 8'd125);  // top unit
    add_row(bffa_pkg::FN_TEST,    8'd128, 1, 8'd0, 1'b1, bffa_pkg::ST_OK, 8'd125);
    add_row(bffa_pkg::FN_MARK,    8'd128, 1, 8'd0, 1'b1, bffa_pkg::ST_OK, 8'd124);  // set bit
    add_row(bffa_pkg::FN_RELEASE, 8'd128, 1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd125);
    add_row(bffa_pkg::FN_TEST,    8'd128, 1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd125);
    add_row(bffa_pkg::FN_MARK,    8'd3,   1, 8'd0, 1'b1, bffa_pkg::ST_OK, 8'd124);
    add_row(bffa_pkg::FN_ALLOC,   8'd7,   1, 8'd4, 1'b1, bffa_pkg::ST_OK, 8'd123);  // skips 1-3
    add_row(bffa_pkg::FN_RELEASE, 8'd2,   1, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd124);
    add_row(bffa_pkg::FN_ALLOC,   8'd0,   1, 8'd2, 1'b1, bffa_pkg::ST_OK, 8'd123);  // hole reused
    // the rest goes through the predictor: word boundaries of the scan
    add_row(bffa_pkg::FN_MARK,    8'd32,  0, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd0);
    add_row(bffa_pkg::FN_MARK,    8'd33,  0, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd0);
    add_row(bffa_pkg::FN_TEST,    8'd33,  0, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd0);
    add_row(bffa_pkg::FN_TEST,    8'd34,  0, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd0);
    add_row(bffa_pkg::FN_MARK,    8'd64,  0, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd0);
    add_row(bffa_pkg::FN_RELEASE, 8'd97,  0, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd0);
    add_row(bffa_pkg::FN_ALLOC,   8'd128, 0, 8'd0, 1'b0, bffa_pkg::ST_OK, 8'd0);

    // single reset at the start of the run
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < directed_rows.size(); i++) begin
      send_request(directed_rows[i].func, directed_rows[i].unit,
                   directed_rows[i].typed, directed_rows[i].res);
    end
    drain_results();

    // random part, shaped as scenarios of whole request sequences
    phase = 0;
    while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
      // receiver holds off early and once mid-run while the sender keeps going
      if (phase == 1) hold_requests++;
      if (!mid_hold_done && items_sent > RANDOM_ITEMS / 2) begin
        hold_requests++;
        mid_hold_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // mixed traffic over all request kinds
        n = $urandom_range(40, 120);
        for (i = 0; i < n; i++) send_plain(bffa_pkg::func_e'($urandom_range(0, 3)), pick_unit());
      end else if (kind <= 6) begin
        // exhaustion by allocate; a double release leaves the counter ahead of
        // the map so the scan can come up empty with a nonzero counter
        if ($urandom_range(0, 1) == 0) begin
          u = 8'($urandom_range(1, bffa_pkg::CAPACITY));
          send_plain(bffa_pkg::FN_RELEASE, u);
          send_plain(bffa_pkg::FN_RELEASE, u);
        end
        n = free_count + $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 19) == 0) send_plain(bffa_pkg::FN_TEST, pick_unit());
          else send_plain(bffa_pkg::FN_ALLOC, 8'($urandom_range(0, 255)));
        end
        n = $urandom_range(10, 50);
        for (i = 0; i < n; i++) send_plain(bffa_pkg::FN_RELEASE, pick_unit());
      end else if (kind == 7) begin
        // marks drive the counter to zero with clear bits still in the map
        n = free_count + $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          send_plain(bffa_pkg::FN_MARK, 8'($urandom_range(1, bffa_pkg::CAPACITY)));
        end
        n = $urandom_range(2, 6);
        for (i = 0; i < n; i++) send_plain(bffa_pkg::FN_ALLOC, 8'($urandom_range(0, 255)));
        n = $urandom_range(20, 60);
        for (i = 0; i < n; i++) send_plain(bffa_pkg::FN_RELEASE, pick_unit());
      end else begin
        // release heavy, pushes the counter against its upper limit
        n = $urandom_range(30, 90);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) send_plain(bffa_pkg::FN_TEST, pick_unit());
          else send_plain(bffa_pkg::FN_RELEASE, pick_unit());
        end
      end
      // sender pauses for a full drain every so often
      if (phase == 2 || $urandom_range(0, 2) == 0) drain_results();
      phase++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
